// File: rtl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned DIV_W  = 32;

    localparam logic [IDX_W-1:0] REG_TEMP_CAL   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_MID  = 2'd2;
    localparam logic [IDX_W-1:0] REG_PRESS_HIGH = 2'd3;

    // Payload carried alongside the divider pipeline.
    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] temp;
        logic        zero_den;
        logic        use_shl;
    } t_div_side;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

// File: rtl/ptc_divider.sv
`default_nettype none
// Pipelined unsigned restoring divider, one quotient bit per stage.
module ptc_divider (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [31:0]            i_num,
    input  wire logic [31:0]            i_den,
    input  wire ptc_pkg::t_div_side     i_side,
    output logic                        o_valid,
    output logic [31:0]                 o_quot,
    output ptc_pkg::t_div_side          o_side
);
    localparam int unsigned N = ptc_pkg::DIV_W;

    logic [N:0]            r_vld;
    logic [N-1:0]          r_num  [0:N];
    logic [N-1:0]          r_den  [0:N];
    logic [N:0]            r_rem  [0:N];
    ptc_pkg::t_div_side    r_side [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[N-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_num[0]  <= i_num;
        r_den[0]  <= i_den;
        r_rem[0]  <= '0;
        r_side[0] <= i_side;
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [N:0]   n_trial;
        logic [N:0]   n_rem;
        logic [N-1:0] n_num;
        always_comb begin
            n_trial = {r_rem[s][N-1:0], r_num[s][N-1]};
            if (n_trial >= {1'b0, r_den[s]}) begin
                n_rem = n_trial - {1'b0, r_den[s]};
                n_num = {r_num[s][N-2:0], 1'b1};
            end else begin
                n_rem = n_trial;
                n_num = {r_num[s][N-2:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            r_num[s+1]  <= n_num;
            r_den[s+1]  <= r_den[s];
            r_rem[s+1]  <= n_rem;
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_vld[N];
    assign o_quot  = r_num[N];
    assign o_side  = r_side[N];
endmodule
`default_nettype wire

// File: rtl/pressure_temperature_compensation.sv
`default_nettype none
// Integer pressure/temperature compensation. One raw pair is taken per
// cycle (start while busy is low; busy is always low); o_done marks its
// result after 8 multiply/add stages, the divider's input register and its
// 32 one-bit stages, two trim stages and the output register, 44 registers
// in all. Results cannot be stalled; the receiver must take each o_done
// cycle. The user must write calibration via i_cfg_we/i_cfg_idx/i_cfg_data
// only while no transaction is in flight; the block does not enforce it. A
// zero pressure denominator gives o_pressure_pa 0, o_pressure_valid low.
module pressure_temperature_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [19:0] i_raw_pressure,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    output logic             o_done,
    output logic [31:0]      o_fine_temperature,
    output logic [31:0]      o_temperature_centi,
    output logic [31:0]      o_pressure_pa,
    output logic             o_pressure_valid
);
    logic [47:0] r_tcal, r_pcl, r_pcm, r_pch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0; r_pcl <= '0; r_pcm <= '0; r_pch <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptc_pkg::REG_TEMP_CAL:   r_tcal <= i_cfg_data;
                ptc_pkg::REG_PRESS_LOW:  r_pcl  <= i_cfg_data;
                ptc_pkg::REG_PRESS_MID:  r_pcm  <= i_cfg_data;
                ptc_pkg::REG_PRESS_HIGH: r_pch  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, r_tcal[15:0]};
    assign t2 = ptc_pkg::sx16(r_tcal[31:16]);
    assign t3 = ptc_pkg::sx16(r_tcal[47:32]);
    assign p1 = {16'd0, r_pcl[15:0]};
    assign p2 = ptc_pkg::sx16(r_pcl[31:16]);
    assign p3 = ptc_pkg::sx16(r_pcl[47:32]);
    assign p4 = ptc_pkg::sx16(r_pcm[15:0]);
    assign p5 = ptc_pkg::sx16(r_pcm[31:16]);
    assign p6 = ptc_pkg::sx16(r_pcm[47:32]);
    assign p7 = ptc_pkg::sx16(r_pch[15:0]);
    assign p8 = ptc_pkg::sx16(r_pch[31:16]);
    assign p9 = ptc_pkg::sx16(r_pch[47:32]);

    // front valid chain, stages 1..8
    logic [8:1] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[7:1], start & ~busy};
    end

    // stage 1: temperature differences
    logic [31:0] r1_x, r1_d; logic [19:0] r1_adcp;
    always_ff @(posedge i_clk) begin
        r1_x    <= {15'd0, i_raw_temperature[19:3]} - (t1 << 1);
        r1_d    <= {16'd0, i_raw_temperature[19:4]} - t1;
        r1_adcp <= i_raw_pressure;
    end
    // stage 2: products
    logic [31:0] r2_a, r2_dd; logic [19:0] r2_adcp;
    always_ff @(posedge i_clk) begin
        r2_a    <= ptc_pkg::asr32(r1_x * t2, 11);
        r2_dd   <= ptc_pkg::asr32(r1_d * r1_d, 12);
        r2_adcp <= r1_adcp;
    end
    // stage 3: fine temperature
    logic [31:0] r3_fine; logic [19:0] r3_adcp;
    always_ff @(posedge i_clk) begin
        r3_fine <= r2_a + ptc_pkg::asr32(r2_dd * t3, 14);
        r3_adcp <= r2_adcp;
    end
    // stage 4: centi temp, pressure var1, square
    logic [31:0] r4_fine, r4_temp, r4_a, r4_sq; logic [19:0] r4_adcp;
    logic [31:0] n4_a, n4_q;
    always_comb begin
        n4_a = ptc_pkg::asr32(r3_fine, 1) - 32'd64000;
        n4_q = ptc_pkg::asr32(n4_a, 2);
    end
    always_ff @(posedge i_clk) begin
        r4_fine <= r3_fine;
        r4_temp <= ptc_pkg::asr32(r3_fine * 32'd5 + 32'd128, 8);
        r4_a    <= n4_a;
        r4_sq   <= n4_q * n4_q;
        r4_adcp <= r3_adcp;
    end
    // stage 5: first pressure products
    logic [31:0] r5_fine, r5_temp, r5_b6, r5_b5, r5_a3, r5_a2; logic [19:0] r5_adcp;
    always_ff @(posedge i_clk) begin
        r5_fine <= r4_fine;
        r5_temp <= r4_temp;
        r5_b6   <= ptc_pkg::asr32(r4_sq, 11) * p6;
        r5_b5   <= (r4_a * p5) << 1;
        r5_a3   <= ptc_pkg::asr32(p3 * ptc_pkg::asr32(r4_sq, 13), 3);
        r5_a2   <= ptc_pkg::asr32(p2 * r4_a, 1);
        r5_adcp <= r4_adcp;
    end
    // stage 6: sums
    logic [31:0] r6_fine, r6_temp, r6_b, r6_s; logic [19:0] r6_adcp;
    logic [31:0] n6_b;
    assign n6_b = r5_b6 + r5_b5;
    always_ff @(posedge i_clk) begin
        r6_fine <= r5_fine;
        r6_temp <= r5_temp;
        r6_b    <= ptc_pkg::asr32(n6_b, 2) + (p4 << 16);
        r6_s    <= 32'd32768 + ptc_pkg::asr32(r5_a3 + r5_a2, 18);
        r6_adcp <= r5_adcp;
    end
    // stage 7: denominator and numerator base
    logic [31:0] r7_fine, r7_temp, r7_den, r7_x;
    always_ff @(posedge i_clk) begin
        r7_fine <= r6_fine;
        r7_temp <= r6_temp;
        r7_den  <= ptc_pkg::asr32(r6_s * p1, 15);
        r7_x    <= (32'd1048576 - {12'd0, r6_adcp}) - ptc_pkg::asr32(r6_b, 12);
    end
    // stage 8: numerator times 3125
    logic [31:0] r8_fine, r8_temp, r8_den, r8_p;
    always_ff @(posedge i_clk) begin
        r8_fine <= r7_fine;
        r8_temp <= r7_temp;
        r8_den  <= r7_den;
        r8_p    <= r7_x * 32'd3125;
    end

    ptc_pkg::t_div_side w_side_in, w_side_out;
    logic w_dv; logic [31:0] w_q;
    assign w_side_in.fine     = r8_fine;
    assign w_side_in.temp     = r8_temp;
    assign w_side_in.zero_den = (r8_den == 32'd0);
    assign w_side_in.use_shl  = ~r8_p[31];

    ptc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[8]),
        .i_num   (r8_p[31] ? r8_p : (r8_p << 1)),
        .i_den   (r8_den),
        .i_side  (w_side_in),
        .o_valid (w_dv),
        .o_quot  (w_q),
        .o_side  (w_side_out)
    );

    // trim stage A: finish quotient, form products
    logic        r9_v, r9_z;
    logic [31:0] r9_fine, r9_temp, r9_p, r9_s;
    logic [31:0] n9_p;
    assign n9_p = w_side_out.use_shl ? w_q : (w_q << 1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else          r9_v <= w_dv;
        r9_fine <= w_side_out.fine;
        r9_temp <= w_side_out.temp;
        r9_z    <= w_side_out.zero_den;
        r9_p    <= n9_p;
        r9_s    <= ({3'd0, n9_p[31:3]} * {3'd0, n9_p[31:3]}) >> 13;
    end
    // trim stage B
    logic        r10_v, r10_z;
    logic [31:0] r10_fine, r10_temp, r10_p, r10_a, r10_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else          r10_v <= r9_v;
        r10_fine <= r9_fine;
        r10_temp <= r9_temp;
        r10_z    <= r9_z;
        r10_p    <= r9_p;
        r10_a    <= ptc_pkg::asr32(p9 * r9_s, 12);
        r10_b    <= ptc_pkg::asr32({2'd0, r9_p[31:2]} * p8, 13);
    end
    // output register
    logic        r_done, r_pv;
    logic [31:0] r_fine, r_temp, r_pa;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r10_v;
        r_fine <= r10_fine;
        r_temp <= r10_temp;
        r_pv   <= ~r10_z;
        r_pa   <= r10_z ? 32'd0
                        : r10_p + ptc_pkg::asr32(r10_a + r10_b + p7, 4);
    end

    assign o_done              = r_done;
    assign o_fine_temperature  = r_fine;
    assign o_temperature_centi = r_temp;
    assign o_pressure_pa       = r_pa;
    assign o_pressure_valid    = r_pv;
endmodule
`default_nettype wire
